/* src/chw_pkg.sv */
package chw_pkg;

	localparam int COORD_BITS = 11;
	localparam int HALF_BITS = COORD_BITS - 1;
	localparam int D_BITS = 2 * COORD_BITS + 1;
	localparam int RR_BITS = 2 * HALF_BITS;
	localparam int TAN_BITS = 20;
	localparam int QM_BITS = COORD_BITS + TAN_BITS;
	localparam int LIM_BITS = D_BITS + 16;
	localparam int CFG_IDX_BITS = 1;
	localparam int N_CELLS = 8;
	localparam int HUE_BITS = 9;

	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 1'b1;

	localparam logic [COORD_BITS-1:0] WIDTH_RESET = COORD_BITS'(256);
	localparam logic [COORD_BITS-1:0] HEIGHT_RESET = COORD_BITS'(256);

	localparam logic [7:0] TAN_LAST = 8'd44;
	localparam logic [15:0] SAT_FULL_SQ = 16'd65025;
	localparam logic [19:0] MICRO = 20'd1000000;
	localparam logic [HUE_BITS:0] HUE_BASE = 10'd270;
	localparam logic [HUE_BITS:0] HUE_WRAP = 10'd360;
	localparam logic [7:0] DEG_90 = 8'd90;
	localparam logic [7:0] DEG_89 = 8'd89;
	localparam logic [7:0] DEG_45 = 8'd45;
	localparam logic [7:0] DEG_180 = 8'd180;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
	} pix_t;

	typedef struct packed {
		logic in_disc;
		logic center;
		logic rz;
		logic ax0;
		logic ay0;
		logic diag;
		logic low;
		logic negx;
		logic negy;
	} side_t;

	typedef struct packed {
		logic valid;
		side_t side;
		logic [COORD_BITS-1:0] p;
		logic [QM_BITS-1:0] qm;
		logic [RR_BITS-1:0] rr;
		logic [LIM_BITS-1:0] lim;
		logic [7:0] n;
		logic [7:0] s;
		logic [15:0] s2;
	} cell_t;

	function automatic logic [TAN_BITS-1:0] tan_micro(input logic [5:0] k);
		logic [TAN_BITS-1:0] v;
		case (k)
			6'd1: v = 20'd17455;
			6'd2: v = 20'd34921;
			6'd3: v = 20'd52408;
			6'd4: v = 20'd69927;
			6'd5: v = 20'd87489;
			6'd6: v = 20'd105104;
			6'd7: v = 20'd122785;
			6'd8: v = 20'd140541;
			6'd9: v = 20'd158384;
			6'd10: v = 20'd176327;
			6'd11: v = 20'd194380;
			6'd12: v = 20'd212557;
			6'd13: v = 20'd230868;
			6'd14: v = 20'd249328;
			6'd15: v = 20'd267949;
			6'd16: v = 20'd286745;
			6'd17: v = 20'd305731;
			6'd18: v = 20'd324920;
			6'd19: v = 20'd344328;
			6'd20: v = 20'd363970;
			6'd21: v = 20'd383864;
			6'd22: v = 20'd404026;
			6'd23: v = 20'd424475;
			6'd24: v = 20'd445229;
			6'd25: v = 20'd466308;
			6'd26: v = 20'd487733;
			6'd27: v = 20'd509525;
			6'd28: v = 20'd531709;
			6'd29: v = 20'd554309;
			6'd30: v = 20'd577350;
			6'd31: v = 20'd600861;
			6'd32: v = 20'd624869;
			6'd33: v = 20'd649408;
			6'd34: v = 20'd674509;
			6'd35: v = 20'd700208;
			6'd36: v = 20'd726543;
			6'd37: v = 20'd753554;
			6'd38: v = 20'd781286;
			6'd39: v = 20'd809784;
			6'd40: v = 20'd839100;
			6'd41: v = 20'd869287;
			6'd42: v = 20'd900404;
			6'd43: v = 20'd932515;
			6'd44: v = 20'd965689;
			default: v = 20'd0;
		endcase
		return v;
	endfunction

endpackage

/* src/chw_ifs.sv */
interface chw_pix_if;
	logic valid;
	logic ready;
	logic [chw_pkg::COORD_BITS-1:0] pixel_x;
	logic [chw_pkg::COORD_BITS-1:0] pixel_y;
	modport source(output valid, pixel_x, pixel_y, input ready);
	modport sink(input valid, pixel_x, pixel_y, output ready);
endinterface

interface chw_res_if;
	logic valid;
	logic ready;
	logic inside_disc;
	logic [chw_pkg::HUE_BITS-1:0] hue_deg;
	logic [7:0] saturation;
	modport source(output valid, inside_disc, hue_deg, saturation, input ready);
	modport sink(input valid, inside_disc, hue_deg, saturation, output ready);
endinterface

interface chw_cfg_if;
	logic valid;
	logic ready;
	logic [chw_pkg::CFG_IDX_BITS-1:0] index;
	logic [chw_pkg::COORD_BITS-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* src/chw_prep.sv */
module chw_prep (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  chw_pkg::pix_t in_pix,
	input  logic [chw_pkg::COORD_BITS-1:0] wheel_width,
	input  logic [chw_pkg::COORD_BITS-1:0] wheel_height,
	output chw_pkg::cell_t out
);
	localparam int CB = chw_pkg::COORD_BITS;
	localparam int HB = chw_pkg::HALF_BITS;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	chw_pkg::pix_t pix_s1;

	logic signed [CB:0] dx, dy;
	logic [CB-1:0] a_s2, b_s2;
	logic negx_s2, negy_s2;
	logic [HB-1:0] r_s2;

	logic [2*CB-1:0] aa_s3, bb_s3;
	logic [chw_pkg::RR_BITS-1:0] rr_s3;
	logic [CB-1:0] a_s3, b_s3;
	logic negx_s3, negy_s3, rz_s3;

	logic [chw_pkg::D_BITS-1:0] d;
	logic [chw_pkg::D_BITS-1:0] d_s4;
	chw_pkg::side_t side_s4;
	logic [CB-1:0] q_s4, p_s4;
	logic [chw_pkg::RR_BITS-1:0] rr_s4;
	chw_pkg::cell_t out_q;

	assign dx = $signed({1'b0, pix_s1.pixel_x}) - $signed({2'b0, wheel_width[CB-1:1]});
	assign dy = $signed({1'b0, pix_s1.pixel_y}) - $signed({2'b0, wheel_height[CB-1:1]});
	assign d = chw_pkg::D_BITS'(aa_s3) + chw_pkg::D_BITS'(bb_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			out_q <= '0;
		end else if (en) begin
			valid_s1 <= in_valid;
			pix_s1 <= in_pix;

			valid_s2 <= valid_s1;
			a_s2 <= dx[CB] ? CB'(-dx) : CB'(dx);
			b_s2 <= dy[CB] ? CB'(-dy) : CB'(dy);
			negx_s2 <= dx[CB];
			negy_s2 <= dy[CB];
			r_s2 <= wheel_width[CB-1:1];

			valid_s3 <= valid_s2;
			aa_s3 <= a_s2 * a_s2;
			bb_s3 <= b_s2 * b_s2;
			rr_s3 <= r_s2 * r_s2;
			a_s3 <= a_s2;
			b_s3 <= b_s2;
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
			rz_s3 <= (r_s2 == '0);

			valid_s4 <= valid_s3;
			d_s4 <= d;
			side_s4.in_disc <= (d <= chw_pkg::D_BITS'(rr_s3));
			side_s4.center <= (a_s3 == '0) && (b_s3 == '0);
			side_s4.rz <= rz_s3;
			side_s4.ax0 <= (b_s3 == '0);
			side_s4.ay0 <= (a_s3 == '0);
			side_s4.diag <= (a_s3 == b_s3);
			side_s4.low <= (b_s3 < a_s3);
			side_s4.negx <= negx_s3;
			side_s4.negy <= negy_s3;
			q_s4 <= (b_s3 < a_s3) ? b_s3 : a_s3;
			p_s4 <= (b_s3 < a_s3) ? a_s3 : b_s3;
			rr_s4 <= rr_s3;

			out_q.valid <= valid_s4;
			out_q.side <= side_s4;
			out_q.p <= p_s4;
			out_q.qm <= chw_pkg::QM_BITS'(q_s4) * chw_pkg::QM_BITS'(chw_pkg::MICRO);
			out_q.rr <= rr_s4;
			out_q.lim <= chw_pkg::LIM_BITS'(d_s4) * chw_pkg::LIM_BITS'(chw_pkg::SAT_FULL_SQ);
			out_q.n <= '0;
			out_q.s <= '0;
			out_q.s2 <= '0;
		end
	end

	assign out = out_q;
endmodule

/* src/chw_cell.sv */
module chw_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [2:0] step,
	input  chw_pkg::cell_t in,
	output chw_pkg::cell_t out
);
	logic [7:0] tn, ts;
	logic [15:0] ts2;
	logic [chw_pkg::QM_BITS-1:0] pt;
	logic [chw_pkg::LIM_BITS-1:0] m;
	logic take_n, take_s;
	chw_pkg::cell_t out_q;

	always_comb begin
		tn = in.n | (8'd1 << step);
		ts = in.s | (8'd1 << step);
		ts2 = in.s2 + ({8'd0, in.s} << (step + 3'd1)) + (16'd1 << {step, 1'b0});
		pt = chw_pkg::QM_BITS'(in.p) * chw_pkg::QM_BITS'(chw_pkg::tan_micro(tn[5:0]));
		m = chw_pkg::LIM_BITS'(ts2) * chw_pkg::LIM_BITS'(in.rr);
		take_n = (tn <= chw_pkg::TAN_LAST) && (in.qm > pt);
		take_s = (m <= in.lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (en) begin
			out_q <= in;
			if (take_n) begin
				out_q.n <= tn;
			end
			if (take_s) begin
				out_q.s <= ts;
				out_q.s2 <= ts2;
			end
		end
	end

	assign out = out_q;
endmodule

/* src/color_wheel_hue_saturation.sv */
// Colour wheel evaluator: for each pixel coordinate it reports whether the
// pixel lies on the wheel disc, its hue in whole degrees and its saturation.
// Unless res stalls, the pix channel takes one item per clock holding
// pixel_x and pixel_y; the res channel returns one item per pixel holding
// inside_disc, hue_deg and saturation, in the order the pixels were taken.
// The cfg channel writes wheel_width (index 0) and wheel_height (index 1);
// it is always ready and should only be written while no pixel is in flight.
// Each pixel passes through 14 register stages on its way to res.
// The pipeline takes one item per cycle while res is not stalled: five
// preparation stages feed a chain of eight search cells, each settling
// one bit of the angle count and one bit of the saturation root.
// When a result waits on res the whole pipeline holds and pix.ready falls;
// it rises as soon as the waiting result is taken.
// Reset clears all pipeline valid flags and sets both dimensions to 256.
module color_wheel_hue_saturation (
	input  logic clk,
	input  logic arst_n,
	chw_cfg_if.sink cfg,
	chw_pix_if.sink pix,
	chw_res_if.source res
);
	localparam int NC = chw_pkg::N_CELLS;

	logic en;
	logic [chw_pkg::COORD_BITS-1:0] width_q, height_q;
	chw_pkg::pix_t pix_in;
	chw_pkg::cell_t chain [NC+1];
	chw_pkg::cell_t last;

	logic valid_q, inside_q;
	logic [chw_pkg::HUE_BITS-1:0] hue_q;
	logic [7:0] sat_q;

	logic [7:0] f, mag;
	logic exact;
	logic [chw_pkg::HUE_BITS:0] hsum, hue;

	assign en = !valid_q || res.ready;
	assign pix.ready = en;
	assign cfg.ready = 1'b1;
	assign pix_in.pixel_x = pix.pixel_x;
	assign pix_in.pixel_y = pix.pixel_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= chw_pkg::WIDTH_RESET;
			height_q <= chw_pkg::HEIGHT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				chw_pkg::REG_WIDTH: width_q <= cfg.data;
				chw_pkg::REG_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	chw_prep u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(pix.valid),
		.in_pix(pix_in),
		.wheel_width(width_q),
		.wheel_height(height_q),
		.out(chain[0])
	);

	for (genvar i = 0; i < NC; i++) begin : g_cell
		chw_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.step(3'(NC - 1 - i)),
			.in(chain[i]),
			.out(chain[i+1])
		);
	end

	assign last = chain[NC];

	always_comb begin
		exact = 1'b1;
		if (last.side.ax0) begin
			f = '0;
		end else if (last.side.ay0) begin
			f = chw_pkg::DEG_90;
		end else if (last.side.diag) begin
			f = chw_pkg::DEG_45;
		end else if (last.side.low) begin
			f = last.n;
			exact = 1'b0;
		end else begin
			f = chw_pkg::DEG_89 - last.n;
			exact = 1'b0;
		end
		if (last.side.center) begin
			mag = '0;
		end else if (last.side.negx) begin
			mag = chw_pkg::DEG_180 - (exact ? f : f + 8'd1);
		end else begin
			mag = f;
		end
		hsum = chw_pkg::HUE_BASE + {2'b0, mag};
		if (last.side.negy) begin
			hue = chw_pkg::HUE_BASE - {2'b0, mag};
		end else if (hsum >= chw_pkg::HUE_WRAP) begin
			hue = hsum - chw_pkg::HUE_WRAP;
		end else begin
			hue = hsum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= last.valid;
			inside_q <= last.side.in_disc;
			hue_q <= last.side.in_disc ? hue[chw_pkg::HUE_BITS-1:0] : '0;
			sat_q <= (last.side.in_disc && !last.side.rz) ? last.s : '0;
		end
	end

	assign res.valid = valid_q;
	assign res.inside_disc = inside_q;
	assign res.hue_deg = hue_q;
	assign res.saturation = sat_q;
endmodule

/* verif/chw_checker.sv */
module chw_checker (
	input  logic clk,
	input  logic arst_n,
	chw_cfg_if.sink cfg_mon,
	chw_pix_if.sink pix_mon,
	chw_res_if.sink res_mon,
	output int fail_count,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic inside_disc;
		logic [chw_pkg::HUE_BITS-1:0] hue_deg;
		logic [7:0] saturation;
	} wheel_res_t;

	localparam int TAN_TABLE [45] = '{
		0, 17455, 34921, 52408, 69927, 87489, 105104, 122785, 140541, 158384,
		176327, 194380, 212557, 230868, 249328, 267949, 286745, 305731, 324920,
		344328, 363970, 383864, 404026, 424475, 445229, 466308, 487733, 509525,
		531709, 554309, 577350, 600861, 624869, 649408, 674509, 700208, 726543,
		753554, 781286, 809784, 839100, 869287, 900404, 932515, 965689
	};

	logic [chw_pkg::COORD_BITS-1:0] width_q, height_q;
	wheel_res_t expected_pixels [$];

	function automatic int whole_degrees(longint q, longint p);
		int n;
		n = 0;
		for (int k = 1; k <= 44; k++)
			if (q * 1000000 > p * TAN_TABLE[k])
				n++;
		return n;
	endfunction

	function automatic int root_saturation(longint d, longint r);
		int s;
		int t;
		longint m;
		s = 0;
		if (r == 0)
			return 0;
		for (int bitpos = 7; bitpos >= 0; bitpos--) begin
			t = s | (1 << bitpos);
			m = t * r;
			if (m * m <= 65025 * d)
				s = t;
		end
		return s;
	endfunction

	function automatic wheel_res_t colour_of(logic [chw_pkg::COORD_BITS-1:0] px,
			logic [chw_pkg::COORD_BITS-1:0] py);
		wheel_res_t res;
		longint r, dx, dy, a, b, d;
		int f, mag, t, hue;
		bit exact;
		r = width_q >> 1;
		dx = longint'(px) - r;
		dy = longint'(py) - longint'(height_q >> 1);
		a = dx < 0 ? -dx : dx;
		b = dy < 0 ? -dy : dy;
		d = a * a + b * b;
		res = '0;
		if (d > r * r)
			return res;
		exact = 1;
		t = 0;
		if (a != 0 || b != 0) begin
			if (b == 0) f = 0;
			else if (a == 0) f = 90;
			else if (a == b) f = 45;
			else if (b < a) begin
				f = whole_degrees(b, a);
				exact = 0;
			end else begin
				f = 89 - whole_degrees(a, b);
				exact = 0;
			end
			if (dx >= 0) mag = f;
			else mag = 180 - (exact ? f : f + 1);
			t = dy < 0 ? -mag : mag;
		end
		hue = 270 + t;
		if (hue >= 360)
			hue -= 360;
		res.inside_disc = 1'b1;
		res.hue_deg = hue[chw_pkg::HUE_BITS-1:0];
		res.saturation = 8'(root_saturation(d, r));
		return res;
	endfunction

	assign pending = expected_pixels.size();

	always_ff @(posedge clk or negedge arst_n) begin
		wheel_res_t got, want;
		if (!arst_n) begin
			width_q <= chw_pkg::WIDTH_RESET;
			height_q <= chw_pkg::HEIGHT_RESET;
			fail_count <= 0;
			expected_pixels.delete();
		end else begin
			if (res_mon.valid && res_mon.ready) begin
				got = '{res_mon.inside_disc, res_mon.hue_deg, res_mon.saturation};
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected result %p", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_pixels.pop_front();
					if (got !== want) begin
						$display("%0t: expected %p actual %p", $time, want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (pix_mon.valid && pix_mon.ready)
				expected_pixels.push_back(colour_of(pix_mon.pixel_x, pix_mon.pixel_y));
			if (cfg_mon.valid && cfg_mon.ready) begin
				if (cfg_mon.index == chw_pkg::REG_WIDTH) width_q <= cfg_mon.data;
				else if (cfg_mon.index == chw_pkg::REG_HEIGHT) height_q <= cfg_mon.data;
			end
		end
	end
endmodule

/* verif/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending;
	int send_idle = 0, recv_idle = 0;
	bit long_hold = 0;
	longint cycle_count = 0;

	chw_cfg_if cfg_bus();
	chw_pix_if pix_bus();
	chw_res_if res_bus();

	color_wheel_hue_saturation u_top (.clk, .arst_n, .cfg(cfg_bus.sink),
		.pix(pix_bus.sink), .res(res_bus.source));
	chw_checker u_chk (.clk, .arst_n, .cfg_mon(cfg_bus.sink), .pix_mon(pix_bus.sink),
		.res_mon(res_bus.sink), .fail_count, .pending);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		cfg_bus.valid = 0;
		cfg_bus.index = chw_pkg::REG_WIDTH;
		cfg_bus.data = '0;
		pix_bus.valid = 0;
		pix_bus.pixel_x = '0;
		pix_bus.pixel_y = '0;
		res_bus.ready = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (long_hold) res_bus.ready <= 1'b0;
		else res_bus.ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic write_reg(logic [chw_pkg::CFG_IDX_BITS-1:0] idx,
			logic [chw_pkg::COORD_BITS-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic send_pixel(int px, int py);
		while ($urandom_range(99) < send_idle) begin
			pix_bus.valid <= 1'b0;
			@(posedge clk);
		end
		pix_bus.valid <= 1'b1;
		pix_bus.pixel_x <= chw_pkg::COORD_BITS'(px);
		pix_bus.pixel_y <= chw_pkg::COORD_BITS'(py);
		do @(posedge clk); while (!pix_bus.ready);
	endtask

	task automatic drain();
		pix_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic configure(int w, int h);
		write_reg(chw_pkg::REG_WIDTH, chw_pkg::COORD_BITS'(w));
		write_reg(chw_pkg::REG_HEIGHT, chw_pkg::COORD_BITS'(h));
	endtask

	task automatic random_pixels(int n, int w, int h);
		int r, cx, cy;
		r = w / 2;
		cx = w / 2;
		cy = h / 2;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) < 7)
				send_pixel(cx - r + $urandom_range(2 * r), cy - r + $urandom_range(2 * r));
			else
				send_pixel($urandom_range(2047), $urandom_range(2047));
		end
	endtask

	initial begin
		int sizes [5][2];
		sizes = '{'{2047, 2047}, '{2, 1}, '{1, 2047}, '{100, 60}, '{0, 0}};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: centre, axes, diagonals, extremes at reset geometry.
		send_pixel(128, 128); send_pixel(256, 128); send_pixel(0, 128);
		send_pixel(128, 0); send_pixel(128, 256); send_pixel(228, 228);
		send_pixel(28, 28); send_pixel(228, 28); send_pixel(28, 228);
		send_pixel(200, 150); send_pixel(150, 200); send_pixel(60, 100);
		send_pixel(0, 0); send_pixel(2047, 2047); send_pixel(2047, 0);
		send_pixel(129, 128); send_pixel(127, 128); send_pixel(128, 127);
		drain();
		sizes[4] = '{$urandom_range(2, 2047), $urandom_range(1, 2047)};
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = ph == 0 ? 32 : (ph == 1 ? 87 : 0);
			recv_idle = ph == 0 ? 87 : (ph == 1 ? 32 : 0);
			if (ph == 2) begin
				configure(256, 256);
				fork
					begin
						long_hold = 1;
						repeat (300) @(posedge clk);
						long_hold = 0;
					end
					random_pixels(60, 256, 256);
				join
				drain();
			end
			foreach (sizes[s]) begin
				configure(sizes[s][0], sizes[s][1]);
				if (s == 0) begin
					send_pixel(0, 1023); send_pixel(2046, 1023);
					send_pixel(1023, 0); send_pixel(1023, 2046);
				end
				random_pixels(50, sizes[s][0], sizes[s][1]);
				drain();
			end
		end
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
